// ----- design/assert_macros.svh -----
// Assertion macros for the RTL files, included by bezier_spline_eval.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPL(label, cond, msg)
`define ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ----- design/bse_pkg.sv -----
// Package: types and constants of the Bezier spline evaluator.
`default_nettype none
package bse_pkg;
    localparam int DefMaxPoints = 64;
    localparam int CoordW       = 32;
    localparam int SegW         = 6;
    localparam int TW           = 18;
    localparam int FracW        = 16;
    localparam int NumPtsW      = 7;
    localparam logic [NumPtsW-1:0] NumPtsReset = 7'd2;
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;
    localparam logic [0:0] REG_NUM_POINTS = 1'b0;

    typedef logic signed [CoordW-1:0] coord_t;
    // x in the low bits
    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } vec3_t;
    // pos in the low bits, same order as the request payload
    typedef struct packed {
        vec3_t hout;
        vec3_t hin;
        vec3_t pos;
    } point_t;
endpackage
`default_nettype wire

// ----- design/bezier_spline_eval.sv -----
// Top level: control point table and pipelined cubic Bezier spline evaluator.
// Channel  Dir  Handshake                 Payload
// s_axis   in   s_axis_tvalid/tready      tdata, tuser=mode
// m_axis   out  m_axis_tvalid/tready      tdata
// apb      in   psel/penable/pwrite       num_points at address 0
// One request per cycle while the output is not stalled; an evaluate request passes
// through table read, operand register, three lerp levels and output register.
// The pipeline advances as a whole; a stalled output holds every stage.
// Reset clears valid bits and num_points (2); the table is not cleared.
`default_nettype none
`include "assert_macros.svh"
module bezier_spline_eval #(
    parameter int MAX_POINTS = bse_pkg::DefMaxPoints
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire [2:0]    paddr,
    input  wire [31:0]   pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x,y,z, handle_in_x,y,z, handle_out_x,y,z, point_index, t_param
    input  wire [311:0]  s_axis_tdata,
    // mode
    input  wire          s_axis_tuser,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // out_x, out_y, out_z, segment, pad
    output logic [103:0] m_axis_tdata
);
    import bse_pkg::*;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CapPoints = (MAX_POINTS < 64) ? MAX_POINTS : 64;
    localparam int PW = $bits(point_t);
    localparam int NS = 6;

    logic [NumPtsW-1:0] num_points_reg;
    logic [NumPtsW-1:0] n_use;
    logic               adv;
    logic [NS-1:0]      vld_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NUM_POINTS) ? {25'd0, num_points_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= NumPtsReset;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_NUM_POINTS)
        begin
            num_points_reg <= pwdata[NumPtsW-1:0];
        end
    end

    always_comb
    begin
        if (num_points_reg == '0)
            n_use = 7'd1;
        else if (32'(num_points_reg) > CapPoints)
            n_use = NumPtsW'(CapPoints);
        else
            n_use = num_points_reg;
    end

    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    point_t              in_pt;
    logic [SegW-1:0]     in_idx;
    logic signed [TW-1:0] in_t;
    assign in_pt  = point_t'(s_axis_tdata[287:0]);
    assign in_idx = s_axis_tdata[293:288];
    assign in_t   = s_axis_tdata[311:294];

    logic acc;
    logic wr_en;
    assign acc   = s_axis_tvalid && s_axis_tready;
    assign wr_en = acc && s_axis_tuser == MODE_WRITE && 32'(in_idx) < MAX_POINTS;

    // stage 0: decode t, segment, fraction
    logic signed [TW+NumPtsW:0] scaled;
    logic [SegW-1:0] seg_c, seg0_reg;
    logic [FracW-1:0] s_c, s0_reg;
    logic kind_c, kind0_reg; // high for an endpoint or a single point
    logic [SegW-1:0] ra_c, rb_c;
    assign scaled = $signed(in_t) * $signed({1'b0, n_use - 7'd1});
    always_comb
    begin
        s_c = scaled[FracW-1:0];
        if (in_t <= 0 || n_use == 7'd1)
        begin
            seg_c = '0; kind_c = 1'b1; ra_c = '0; rb_c = '0;
        end
        else if (in_t >= 18'sd65536)
        begin
            seg_c = SegW'(n_use - 7'd1); kind_c = 1'b1; ra_c = seg_c; rb_c = seg_c;
        end
        else
        begin
            seg_c = scaled[FracW+SegW-1:FracW]; kind_c = 1'b0;
            ra_c = seg_c; rb_c = seg_c + 6'd1;
        end
    end

    logic [PW-1:0] rd_a, rd_b;
    logic ev_c;
    assign ev_c = acc && s_axis_tuser == MODE_EVAL;

    // read both entries (two RAM copies, shared write)
    bse_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_ram_a (
        .clk(clk), .we(wr_en), .waddr(AW'(in_idx)), .wdata(in_pt),
        .re(adv), .raddr(AW'(ra_c)), .rdata(rd_a));
    bse_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_ram_b (
        .clk(clk), .we(wr_en), .waddr(AW'(in_idx)), .wdata(in_pt),
        .re(adv), .raddr(AW'(rb_c)), .rdata(rd_b));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            seg0_reg <= seg_c; s0_reg <= s_c; kind0_reg <= kind_c;
        end
    end

    // stage 1: operands
    point_t pa, pb;
    assign pa = point_t'(rd_a);
    assign pb = point_t'(rd_b);
    coord_t p0_reg [3], p1_reg [3], p2_reg [3], p3_reg [3];
    logic [FracW-1:0] s1_reg;
    logic [SegW-1:0] seg1_reg;
    logic end1_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_reg[0] <= pa.pos.x;  p0_reg[1] <= pa.pos.y;  p0_reg[2] <= pa.pos.z;
            p1_reg[0] <= pa.hout.x; p1_reg[1] <= pa.hout.y; p1_reg[2] <= pa.hout.z;
            p2_reg[0] <= pb.hin.x;  p2_reg[1] <= pb.hin.y;  p2_reg[2] <= pb.hin.z;
            p3_reg[0] <= pb.pos.x;  p3_reg[1] <= pb.pos.y;  p3_reg[2] <= pb.pos.z;
            s1_reg <= s0_reg; seg1_reg <= seg0_reg; end1_reg <= kind0_reg;
        end
    end

    // stages 2-4: de Casteljau levels
    coord_t la [3], lb [3], lc [3], ld [3], le [3], lf [3];
    coord_t p0d2_reg [3], p0d3_reg [3], p0d4_reg [3];
    logic [FracW-1:0] s2_reg, s3_reg;
    logic [SegW-1:0] seg2_reg, seg3_reg, seg4_reg;
    logic end2_reg, end3_reg, end4_reg;
    for (genvar k = 0; k < 3; k++)
    begin : g_axis
        bse_lerp u_a (.clk(clk), .en(adv), .a(p0_reg[k]), .b(p1_reg[k]), .s(s1_reg), .y(la[k]));
        bse_lerp u_b (.clk(clk), .en(adv), .a(p1_reg[k]), .b(p2_reg[k]), .s(s1_reg), .y(lb[k]));
        bse_lerp u_c (.clk(clk), .en(adv), .a(p2_reg[k]), .b(p3_reg[k]), .s(s1_reg), .y(lc[k]));
        bse_lerp u_d (.clk(clk), .en(adv), .a(la[k]), .b(lb[k]), .s(s2_reg), .y(ld[k]));
        bse_lerp u_e (.clk(clk), .en(adv), .a(lb[k]), .b(lc[k]), .s(s2_reg), .y(le[k]));
        bse_lerp u_f (.clk(clk), .en(adv), .a(ld[k]), .b(le[k]), .s(s3_reg), .y(lf[k]));
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                p0d2_reg[k] <= p0_reg[k];
                p0d3_reg[k] <= p0d2_reg[k];
                p0d4_reg[k] <= p0d3_reg[k];
            end
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg <= s1_reg; s3_reg <= s2_reg;
            seg2_reg <= seg1_reg; seg3_reg <= seg2_reg; seg4_reg <= seg3_reg;
            end2_reg <= end1_reg; end3_reg <= end2_reg; end4_reg <= end3_reg;
        end
    end

    // stage 5: output register
    logic [103:0] out_next;
    always_comb
    begin
        if (end4_reg)
            out_next = {2'b00, seg4_reg, p0d4_reg[2], p0d4_reg[1], p0d4_reg[0]};
        else
            out_next = {2'b00, seg4_reg, lf[2], lf[1], lf[0]};
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_axis_tdata <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NS-2:0], ev_c};
        end
    end
    assign m_axis_tvalid = vld_reg[NS-1];

    `ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")
    `ASSERT_IMPL(a_ready, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready not tied to output slot")
    `ASSERT_NEXT(a_shift, adv && vld_reg[0], vld_reg[1], "valid bit lost in pipeline")
endmodule
`default_nettype wire

// ----- design/bse_ram.sv -----
// Generic single-write, single-read RAM with registered read.
`default_nettype none
module bse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire                     re,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ----- design/bse_lerp.sv -----
// One pipelined linear interpolation stage: a + round((b - a) * s / 65536).
`default_nettype none
module bse_lerp (
    input  wire                   clk,
    input  wire                   en,
    input  wire signed [31:0]     a,
    input  wire signed [31:0]     b,
    input  wire [15:0]            s,
    output logic signed [31:0]    y
);
    import bse_pkg::*;
    logic signed [32:0] diff;
    logic signed [50:0] prod;
    logic signed [50:0] sum;

    always_comb
    begin
        diff = 33'(b) - 33'(a);
        prod = 51'(diff) * $signed({35'd0, s});
        sum  = prod + 51'sd32768;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y <= a + 32'(sum >>> FracW);
        end
    end
endmodule
`default_nettype wire
